// File: src/elsr_pkg.sv
// Package for the ELLPACK row engine: sizes, action codes and the
// control record passed from the slot control stage to the MAC stage.
// No dependencies.
`timescale 1ns / 1ps

package elsr_pkg;

    // Vector store size and address width.
    localparam int VECTOR_DEPTH  = 1024;
    localparam int VEC_ADDR_W    = $clog2(VECTOR_DEPTH);

    // Row width limits and counter widths.
    localparam int MAX_ROW_WIDTH = 16;
    localparam int CNT_W         = $clog2(MAX_ROW_WIDTH);
    localparam int RW_W          = 5;

    // Field widths.
    localparam int POS_W         = 10;
    localparam int VAL_W         = 32;
    localparam int SUM_W         = 48;
    localparam int ROW_W         = 16;
    localparam int PROD_W        = 2 * VAL_W;
    localparam int FRAC_W        = 24;
    localparam int TERM_W        = PROD_W - FRAC_W;

    // Action codes carried on the input tuser bit.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_SLOT = 1'b1;

    // Per-item control passed to the multiply-accumulate stage.
    typedef struct packed {
        logic             valid;
        logic             clr;
        logic             add_en;
        logic             last;
        logic [ROW_W-1:0] row_num;
    } t_slot_ctl;

endpackage

// File: src/elsr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module elsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/elsr_ctrl.sv
// Slot control stage: input register, row_width register, slot counting,
// padding detection and row numbering. Depends on elsr_pkg.
`timescale 1ns / 1ps

module elsr_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_accept,
    input  logic                       i_action,
    input  logic [elsr_pkg::POS_W-1:0] i_position,
    input  logic [elsr_pkg::VAL_W-1:0] i_value,
    input  logic                       i_cfg_wr_en,
    input  logic [elsr_pkg::RW_W-1:0]  i_cfg_wr_data,
    output elsr_pkg::t_slot_ctl        o_ctl,
    output logic [elsr_pkg::VAL_W-1:0] o_value
);

    import elsr_pkg::*;

    // Input stage register.
    logic             r_s1_valid;
    logic             r_s1_action;
    logic [POS_W-1:0] r_s1_pos;
    logic [VAL_W-1:0] r_s1_value;

    // Row state.
    logic [RW_W-1:0]  r_row_width;
    logic [CNT_W-1:0] r_slot_cnt;
    logic [CNT_W-1:0] n_slot_cnt;
    logic [POS_W-1:0] r_prev_col;
    logic [POS_W-1:0] n_prev_col;
    logic             r_prev_valid;
    logic             n_prev_valid;
    logic             r_pad_seen;
    logic             n_pad_seen;
    logic [ROW_W-1:0] r_row_cnt;
    logic [ROW_W-1:0] n_row_cnt;

    logic [RW_W-1:0]  w_width_eff;
    logic [RW_W-1:0]  w_cnt_next;
    t_slot_ctl        w_ctl;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= RW_W'(7);
        end else if (i_cfg_wr_en) begin
            r_row_width <= i_cfg_wr_data;
        end
    end

    // Input register, loaded on a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_accept) begin
            r_s1_action <= i_action;
            r_s1_pos    <= i_position;
            r_s1_value  <= i_value;
        end
    end

    // Effective width: zero acts as one, large values clamp to the maximum.
    always_comb begin
        if (r_row_width == '0) begin
            w_width_eff = RW_W'(1);
        end else if (r_row_width > RW_W'(MAX_ROW_WIDTH)) begin
            w_width_eff = RW_W'(MAX_ROW_WIDTH);
        end else begin
            w_width_eff = r_row_width;
        end
    end

    assign w_cnt_next = RW_W'(r_slot_cnt) + RW_W'(1);

    // Per-slot decision and next row state.
    always_comb begin
        n_slot_cnt    = r_slot_cnt;
        n_prev_col    = r_prev_col;
        n_prev_valid  = r_prev_valid;
        n_pad_seen    = r_pad_seen;
        n_row_cnt     = r_row_cnt;
        w_ctl         = '0;
        w_ctl.valid   = r_s1_valid;
        w_ctl.row_num = r_row_cnt;
        if (r_s1_valid) begin
            case (r_s1_action)
                ACT_LOAD: begin
                    // A vector load restarts the row and the row numbering.
                    w_ctl.clr    = 1'b1;
                    n_slot_cnt   = '0;
                    n_prev_valid = 1'b0;
                    n_pad_seen   = 1'b0;
                    n_row_cnt    = '0;
                end
                default: begin
                    if (!r_pad_seen) begin
                        if (r_prev_valid && (r_s1_pos == r_prev_col)) begin
                            n_pad_seen = 1'b1;
                        end else begin
                            w_ctl.add_en = 1'b1;
                            n_prev_col   = r_s1_pos;
                            n_prev_valid = 1'b1;
                        end
                    end
                    if (w_cnt_next >= w_width_eff) begin
                        w_ctl.last   = 1'b1;
                        n_slot_cnt   = '0;
                        n_prev_valid = 1'b0;
                        n_pad_seen   = 1'b0;
                        n_row_cnt    = r_row_cnt + ROW_W'(1);
                    end else begin
                        n_slot_cnt = w_cnt_next[CNT_W-1:0];
                    end
                end
            endcase
        end
    end

    // Row state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_cnt   <= '0;
            r_prev_col   <= '0;
            r_prev_valid <= 1'b0;
            r_pad_seen   <= 1'b0;
            r_row_cnt    <= '0;
        end else if (i_adv) begin
            r_slot_cnt   <= n_slot_cnt;
            r_prev_col   <= n_prev_col;
            r_prev_valid <= n_prev_valid;
            r_pad_seen   <= n_pad_seen;
            r_row_cnt    <= n_row_cnt;
        end
    end

    assign o_ctl   = w_ctl;
    assign o_value = r_s1_value;

    // Padding can only be flagged after a real column was recorded.
    a_pad_needs_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad_seen |-> r_prev_valid)
        else $error("padding flag set without a previous column");

    // The end of a row leaves the slot counter at zero.
    a_last_clears_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && w_ctl.last) |=> (r_slot_cnt == '0))
        else $error("slot counter not cleared after row end");

    // A load never adds or ends a row.
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.clr |-> (!w_ctl.add_en && !w_ctl.last))
        else $error("vector load produced a slot action");

endmodule

// File: src/elsr_mac.sv
// Multiply-accumulate stage: product register, saturating Q24.24
// accumulator and result register. Depends on elsr_pkg.
`timescale 1ns / 1ps

module elsr_mac (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  elsr_pkg::t_slot_ctl        i_ctl,
    input  logic [elsr_pkg::VAL_W-1:0] i_value,
    input  logic [elsr_pkg::VAL_W-1:0] i_vec,
    output logic                       o_valid,
    output logic [elsr_pkg::SUM_W-1:0] o_row_sum,
    output logic [elsr_pkg::ROW_W-1:0] o_row_idx
);

    import elsr_pkg::*;

    t_slot_ctl          r_s2_ctl;
    logic [PROD_W-1:0]  r_prod;
    logic [SUM_W-1:0]   r_acc;
    logic               r_out_valid;
    logic [SUM_W-1:0]   r_out_sum;
    logic [ROW_W-1:0]   r_out_row;

    logic [TERM_W-1:0]  w_term;
    logic [SUM_W:0]     w_sum;
    logic [SUM_W-1:0]   w_sat;
    logic [SUM_W-1:0]   w_acc_upd;

    // Product stage: exact Q16.48 product of coefficient and vector element.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
        end else if (i_adv) begin
            r_s2_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= PROD_W'($signed(i_value) * $signed(i_vec));
        end
    end

    // Dropping the low fraction bits of a two's complement word rounds down.
    assign w_term = r_prod[PROD_W-1:FRAC_W];
    assign w_sum  = {r_acc[SUM_W-1], r_acc}
                  + {{(SUM_W + 1 - TERM_W){w_term[TERM_W-1]}}, w_term};

    // Saturate to the signed 48-bit range.
    always_comb begin
        if (w_sum[SUM_W] != w_sum[SUM_W-1]) begin
            w_sat = w_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            w_sat = w_sum[SUM_W-1:0];
        end
    end

    assign w_acc_upd = r_s2_ctl.add_en ? w_sat : r_acc;

    // Accumulator: cleared by a vector load and at the end of each row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_adv && r_s2_ctl.valid) begin
            if (r_s2_ctl.clr || r_s2_ctl.last) begin
                r_acc <= '0;
            end else begin
                r_acc <= w_acc_upd;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_out_valid <= r_s2_ctl.valid && r_s2_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && r_s2_ctl.valid && r_s2_ctl.last) begin
            r_out_sum <= w_acc_upd;
            r_out_row <= r_s2_ctl.row_num;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_row_sum = r_out_sum;
    assign o_row_idx = r_out_row;

    // A vector load leaves a zero row sum behind it.
    a_clr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_s2_ctl.valid && r_s2_ctl.clr) |=> (r_acc == '0))
        else $error("accumulator not cleared by vector load");

    // A result only appears for an item that ended a row.
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !(r_s2_ctl.valid && r_s2_ctl.last)) |=> !r_out_valid)
        else $error("result produced without a row end");

    // Without an advance the result register is left alone.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> ($stable(r_out_valid) && $stable(r_out_sum)))
        else $error("result register changed during a stall");

endmodule

// File: src/ellpack_spmv_row_engine.sv
// ELLPACK sparse matrix by dense vector row engine, top level.
// Depends on elsr_pkg, elsr_ram, elsr_ctrl and elsr_mac.
`timescale 1ns / 1ps

// Usage:
// The slave stream carries both kinds of item. tuser = 0 writes a vector
// element into the store at the position given; tuser = 1 delivers one
// matrix slot (column, coefficient). Matrix rows arrive as row_width slots
// each, written over the configuration port while the block is idle.
// A slot that repeats the previous column of its row marks padding; it and
// the rest of that row add nothing but are still counted.
// After the last slot of a row the master stream carries one transfer with
// the saturated Q24.24 row sum and the row number. A vector load restarts
// row numbering at zero.
// Throughput is one item per cycle while the master stream does not stall:
// the accumulator in the last stage feeds back only through its own register
// and the store does one read or one write per item. The row's last slot
// passes the input, product and result registers before its result is valid.
// Reset clears all row state and sets row_width to 7; the vector store
// keeps no reset value and must be loaded before use.
// When the receiver holds tready low with a result waiting, the whole
// pipeline freezes and the slave tready drops until that result is taken.

module ellpack_spmv_row_engine (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Slave stream. tdata: position[9:0], value[41:10], zeros[47:42].
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [47:0]               i_s_tdata,
    // tuser: action[0].
    input  logic                      i_s_tuser,
    // Master stream. tdata: row_sum[47:0], row_idx[63:48].
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [63:0]               o_m_tdata,
    // Configuration: row_width.
    input  logic                      i_cfg_wr_en,
    input  logic [elsr_pkg::RW_W-1:0] i_cfg_wr_data
);

    import elsr_pkg::*;

    logic             w_adv;
    logic             w_accept;
    logic [POS_W-1:0] w_position;
    logic [VAL_W-1:0] w_value;
    logic [VAL_W-1:0] w_vec;
    logic [VAL_W-1:0] w_s1_value;
    t_slot_ctl        w_ctl;
    logic             w_out_valid;
    logic [SUM_W-1:0] w_row_sum;
    logic [ROW_W-1:0] w_row_idx;

    // The pipeline moves whenever the result register is free or being taken.
    assign w_adv      = !w_out_valid || i_m_tready;
    assign o_s_tready = w_adv;
    assign w_accept   = i_s_tvalid && w_adv;

    // Unpack the input transfer.
    assign w_position = i_s_tdata[POS_W-1:0];
    assign w_value    = i_s_tdata[POS_W+VAL_W-1:POS_W];

    // Vector store: written by loads, read by slots at transfer time.
    elsr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_vec_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept && (i_s_tuser == ACT_LOAD)),
        .i_wr_addr (w_position[VEC_ADDR_W-1:0]),
        .i_wr_data (w_value),
        .i_rd_en   (w_accept && (i_s_tuser == ACT_SLOT)),
        .i_rd_addr (w_position[VEC_ADDR_W-1:0]),
        .o_rd_data (w_vec)
    );

    elsr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_accept      (w_accept),
        .i_action      (i_s_tuser),
        .i_position    (w_position),
        .i_value       (w_value),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_ctl         (w_ctl),
        .o_value       (w_s1_value)
    );

    elsr_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_ctl     (w_ctl),
        .i_value   (w_s1_value),
        .i_vec     (w_vec),
        .o_valid   (w_out_valid),
        .o_row_sum (w_row_sum),
        .o_row_idx (w_row_idx)
    );

    // Pack the output transfer.
    assign o_m_tvalid = w_out_valid;
    assign o_m_tdata  = {w_row_idx, w_row_sum};

endmodule

// File: dv/ellpack_spmv_row_engine_tb.sv
// Testbench for the ELLPACK row engine: loads the dense vector, streams matrix
// rows, and checks every row result against its own row predictor.
// Depends on elsr_pkg and the ellpack_spmv_row_engine RTL.
`timescale 1ns / 1ps

module ellpack_spmv_row_engine_tb;

    import elsr_pkg::*;

    localparam longint ACC_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_MIN   = -ACC_MAX - 1;
    localparam int     HOLD_LEN  = 300;
    localparam int     DRAIN_PAD = 6;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [ROW_W-1:0] row;
    } t_row_result;

    // Block ports.
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_s_tvalid    = 1'b0;
    logic              o_s_tready;
    logic [47:0]       i_s_tdata     = '0;
    logic              i_s_tuser     = 1'b0;
    logic              o_m_tvalid;
    logic              i_m_tready    = 1'b0;
    logic [63:0]       o_m_tdata;
    logic              i_cfg_wr_en   = 1'b0;
    logic [RW_W-1:0]   i_cfg_wr_data = '0;

    // Row predictor state.
    logic signed [VAL_W-1:0] vec_image [VECTOR_DEPTH];
    bit                      vec_written [VECTOR_DEPTH];
    logic [POS_W-1:0]        written_cols [$];
    logic [CNT_W-1:0]        row_slot_cnt;
    logic [POS_W-1:0]        row_prev_col;
    logic                    row_prev_valid;
    logic                    row_pad_seen;
    logic signed [SUM_W-1:0] row_acc;
    logic [ROW_W-1:0]        row_index;
    logic [RW_W-1:0]         cfg_row_width;

    // Rows predicted but not yet seen on the master stream.
    t_row_result expected_rows [$];
    t_row_result head_row;

    // Sender and receiver pacing.
    int  error_count   = 0;
    int  items_sent    = 0;
    int  burst_left    = 0;
    int  hold_requests = 0;
    int  hold_served   = 0;
    int  hold_count    = 0;
    int  rx_stall_pct  = 0;
    int  rx_phase_left = 0;

    ellpack_spmv_row_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #4 i_clk = ~i_clk;

    // Clear the per-row part of the predictor.
    function automatic void clear_row_state();
        row_slot_cnt   = '0;
        row_prev_col   = '0;
        row_prev_valid = 1'b0;
        row_pad_seen   = 1'b0;
        row_acc        = '0;
    endfunction

    // Row width as the block applies it: zero acts as one, large values clamp.
    function automatic int effective_width();
        int w;
        w = int'(cfg_row_width);
        if (w < 1) begin
            w = 1;
        end
        if (w > MAX_ROW_WIDTH) begin
            w = MAX_ROW_WIDTH;
        end
        return w;
    endfunction

    // Advance the row predictor by one accepted item and queue any row result.
    task automatic advance_row_model(input logic act, input logic [POS_W-1:0] pos,
                                     input logic [VAL_W-1:0] val);
        longint      coef;
        longint      elem;
        longint      sum;
        logic [4:0]  cnt_next;
        t_row_result res;
        if (act == ACT_LOAD) begin
            vec_image[pos] = val;
            if (!vec_written[pos]) begin
                vec_written[pos] = 1'b1;
                written_cols.push_back(pos);
            end
            clear_row_state();
            row_index = '0;
            return;
        end
        if (!row_pad_seen) begin
            if (row_prev_valid && pos == row_prev_col) begin
                row_pad_seen = 1'b1;
            end else begin
                coef = $signed(val);
                elem = vec_image[pos];
                sum  = row_acc + ((coef * elem) >>> FRAC_W);
                if (sum > ACC_MAX) begin
                    sum = ACC_MAX;
                end
                if (sum < ACC_MIN) begin
                    sum = ACC_MIN;
                end
                row_acc        = sum[SUM_W-1:0];
                row_prev_col   = pos;
                row_prev_valid = 1'b1;
            end
        end
        cnt_next = {1'b0, row_slot_cnt} + 5'd1;
        if (int'(cnt_next) >= effective_width()) begin
            res.sum = row_acc;
            res.row = row_index;
            expected_rows.push_back(res);
            row_index = row_index + 1'b1;
            clear_row_state();
        end else begin
            row_slot_cnt = cnt_next[CNT_W-1:0];
        end
    endtask

    // Record one failure; only the first few are printed.
    task automatic note_failure(input string msg);
        if (error_count < 10) begin
            $display("ERROR: %s", msg);
        end
        error_count++;
    endtask

    // Send one item on the slave stream, with bursts and gaps, then predict it.
    task automatic send_item(input logic act, input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] val);
        int gap;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 6);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {6'b0, val, pos};
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        items_sent++;
        advance_row_model(act, pos, val);
    endtask

    // Wait until every predicted row has arrived and the pipeline is empty.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (expected_rows.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // Write row_width while the block is idle.
    task automatic write_row_width(input logic [RW_W-1:0] w);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cfg_row_width = w;
    endtask

    // Random Q8.24 value: full range, small magnitudes, or extremes.
    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(4))
            1: begin
                v = $urandom_range(0, 32'h0400_0000);
                if ($urandom_range(1)) begin
                    v = -v;
                end
            end
            2: begin
                case ($urandom_range(3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Column of a loaded vector element, optionally different from one column.
    function automatic logic [POS_W-1:0] pick_column(input logic [POS_W-1:0] avoid,
                                                      input bit do_avoid);
        logic [POS_W-1:0] col;
        col = written_cols[$urandom_range(0, written_cols.size() - 1)];
        while (do_avoid && col == avoid && written_cols.size() > 1) begin
            col = written_cols[$urandom_range(0, written_cols.size() - 1)];
        end
        return col;
    endfunction

    task automatic send_random_slot();
        send_item(ACT_SLOT, pick_column(row_prev_col, row_prev_valid), pick_value());
    endtask

    task automatic send_random_load();
        send_item(ACT_LOAD, POS_W'($urandom_range(0, VECTOR_DEPTH - 1)), pick_value());
    endtask

    // Slots until the current row has ended.
    task automatic finish_row();
        while (row_slot_cnt != 0) begin
            send_random_slot();
        end
    endtask

    // A whole row: some real slots, then, if the row has room, a padding slot and filler.
    task automatic send_well_formed_row();
        int               n_real;
        int               i;
        logic [POS_W-1:0] col;
        n_real = $urandom_range(1, effective_width());
        i = 0;
        do begin
            if (i < n_real) begin
                col = pick_column(row_prev_col, row_prev_valid);
            end else if (i == n_real) begin
                col = row_prev_col;
            end else begin
                col = pick_column('0, 1'b0);
            end
            send_item(ACT_SLOT, col, pick_value());
            i++;
        end while (row_slot_cnt != 0);
    endtask

    // Extreme vector elements and coefficients, floor rounding of negatives.
    task automatic test_directed_arithmetic();
        send_item(ACT_LOAD, 10'd0,    32'h7FFF_FFFF);
        send_item(ACT_LOAD, 10'd1023, 32'h8000_0000);
        send_item(ACT_LOAD, 10'd1,    32'hFFFF_FFFF);
        send_item(ACT_LOAD, 10'd2,    32'h0100_0000);
        send_item(ACT_LOAD, 10'd512,  32'h0000_0000);
        send_item(ACT_LOAD, 10'd341,  $urandom);
        send_item(ACT_LOAD, 10'd682,  $urandom);
        // One row at the reset width of seven slots.
        send_item(ACT_SLOT, 10'd0,    32'h7FFF_FFFF);
        send_item(ACT_SLOT, 10'd1023, 32'h8000_0000);
        send_item(ACT_SLOT, 10'd0,    32'h8000_0000);
        send_item(ACT_SLOT, 10'd1,    32'h0000_0001);
        send_item(ACT_SLOT, 10'd2,    32'hFFFF_FFFF);
        send_item(ACT_SLOT, 10'd512,  $urandom);
        send_item(ACT_SLOT, 10'd341,  $urandom);
    endtask

    // Padding in mid-row, and a vector load that cuts a row short.
    task automatic test_padding_and_reload();
        write_row_width(5'd4);
        send_item(ACT_SLOT, 10'd2,   $urandom);
        send_item(ACT_SLOT, 10'd682, $urandom);
        send_item(ACT_SLOT, 10'd682, $urandom);
        send_item(ACT_SLOT, 10'd0,   $urandom);
        send_item(ACT_SLOT, 10'd1,   $urandom);
        send_item(ACT_LOAD, 10'd3,   $urandom);
        send_item(ACT_SLOT, 10'd3,   $urandom);
        send_item(ACT_SLOT, 10'd2,   $urandom);
        send_item(ACT_SLOT, 10'd1,   $urandom);
        send_item(ACT_SLOT, 10'd0,   $urandom);
    endtask

    // Mostly well-formed rows over many widths, with loads and broken rows mixed in.
    task automatic test_random_rows();
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < 330) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                repeat ($urandom_range(1, 6)) send_random_load();
            end else if (pick < 12) begin
                repeat ($urandom_range(1, 3)) send_random_slot();
                send_random_load();
            end else if (pick < 20) begin
                case ($urandom_range(5))
                    0: write_row_width(5'd0);
                    1: write_row_width(5'd1);
                    2: write_row_width(5'd16);
                    3: write_row_width(RW_W'($urandom_range(17, 31)));
                    default: write_row_width(RW_W'($urandom_range(1, 5)));
                endcase
            end else begin
                send_well_formed_row();
            end
        end
        finish_row();
    endtask

    // Row width rewritten while a row is partly accumulated.
    task automatic test_width_change_mid_row();
        int w1;
        int k;
        repeat (6) begin
            w1 = $urandom_range(2, 16);
            write_row_width(RW_W'(w1));
            k = $urandom_range(1, w1 - 1);
            repeat (k) send_random_slot();
            case ($urandom_range(3))
                0: write_row_width(5'd0);
                1: write_row_width(RW_W'(k));
                2: write_row_width(RW_W'($urandom_range(17, 31)));
                default: write_row_width(RW_W'($urandom_range(1, 16)));
            endcase
            finish_row();
        end
    endtask

    // Receiver holds off for a long stretch while single-slot rows keep coming.
    task automatic test_backpressure();
        write_row_width(5'd1);
        hold_requests <= hold_requests + 1;
        repeat (40) send_random_slot();
        write_row_width(5'd3);
    endtask

    // Receiver: random stall phases, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_count  = HOLD_LEN;
        end
        if (hold_count > 0) begin
            hold_count--;
            i_m_tready <= 1'b0;
        end else begin
            if (rx_phase_left <= 0) begin
                case ($urandom_range(3))
                    0: rx_stall_pct = 0;
                    1: rx_stall_pct = 20;
                    2: rx_stall_pct = 50;
                    default: rx_stall_pct = 80;
                endcase
                rx_phase_left = $urandom_range(5, 60);
            end
            rx_phase_left--;
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Compare each master transfer with the oldest predicted row.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_rows.size() == 0) begin
                note_failure($sformatf("row result with none expected, tdata=%h", o_m_tdata));
            end else begin
                head_row = expected_rows.pop_front();
                if (o_m_tdata[SUM_W-1:0] !== head_row.sum) begin
                    note_failure($sformatf("row %0d row_sum expected %h got %h",
                                           head_row.row, head_row.sum, o_m_tdata[SUM_W-1:0]));
                end
                if (o_m_tdata[63:48] !== head_row.row) begin
                    note_failure($sformatf("row index expected %0d got %0d",
                                           head_row.row, o_m_tdata[63:48]));
                end
            end
        end
    end

    // Main sequence.
    initial begin
        foreach (vec_written[i]) begin
            vec_written[i] = 1'b0;
            vec_image[i]   = '0;
        end
        clear_row_state();
        row_index     = '0;
        cfg_row_width = 5'd7;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_arithmetic();
        test_padding_and_reload();
        test_random_rows();
        test_width_change_mid_row();
        test_backpressure();

        wait_drained();
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #8000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
src/elsr_pkg.sv
src/elsr_ram.sv
src/elsr_ctrl.sv
src/elsr_mac.sv
src/ellpack_spmv_row_engine.sv
dv/ellpack_spmv_row_engine_tb.sv
